### hdl/sbsor_pkg.sv
`default_nettype none
package sbsor_pkg;

  // command codes
  localparam logic [2:0] CMD_ROW_START = 3'd0;
  localparam logic [2:0] CMD_NONZERO   = 3'd1;
  localparam logic [2:0] CMD_LOAD_X    = 3'd2;
  localparam logic [2:0] CMD_LOAD_F    = 3'd3;
  localparam logic [2:0] CMD_RUN       = 3'd4;
  localparam logic [2:0] CMD_READ_X    = 3'd5;

  // result status codes
  localparam logic [1:0] STAT_LOAD_OK   = 2'd0;
  localparam logic [1:0] STAT_RUN_DONE  = 2'd1;
  localparam logic [1:0] STAT_ZERO_DIAG = 2'd2;
  localparam logic [1:0] STAT_READ_DATA = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_RELAX_WEIGHT = 2'd0;
  localparam logic [1:0] CFG_SWEEP_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_ROW_COUNT    = 2'd2;
  localparam logic [1:0] CFG_COMPLEX_MODE = 2'd3;

  // quotient magnitude cap is 2^Q_CAP_BITS, signed quotient is QW bits
  localparam int Q_CAP_BITS = 40;
  localparam int QW         = Q_CAP_BITS + 2;
  localparam int QL_BITS    = 24;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [12:0]        index;
    logic [9:0]         column;
    logic [13:0]        row_start;
    logic signed [31:0] re_value;
    logic signed [31:0] im_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_re;
    logic signed [31:0] out_im;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [QW-1:0] q;
    logic                 sat;
  } div_res_t;

endpackage
`default_nettype wire

### hdl/sbsor_ifs.sv
`default_nettype none
interface sbsor_in_if;
  logic                valid;
  logic                ready;
  sbsor_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sbsor_out_if;
  logic                 valid;
  logic                 ready;
  sbsor_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/sparse_backward_sor_sweeper_top.sv
`default_nettype none
// channel | dir | handshake     | payload
// in_ch   | in  | valid / ready | cmd, index, column, row_start, re_value, im_value
// out_ch  | out | valid / ready | status, out_re, out_im, saturated
// cfg     | in  | cfg_we        | cfg_index, cfg_data
//
// loads are answered from the idle state, a read of x goes through S_READ; one transaction in, one out.
// a run walks the matrix with one shared 32x32 multiplier and a bit-serial
// divider: each off-diagonal nonzero gets a complex multiply-accumulate, each row a
// residual, and each vector component a division and a weighted update.
// reset is synchronous; memories come up undefined and need loading first.
// in_ch.ready is low while a command is in work or the result slot stays full.
module sparse_backward_sor_sweeper_top #(
  parameter int MAX_ROWS     = 1024,
  parameter int MAX_NONZEROS = 8192,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  sbsor_in_if.sink         in_ch,
  sbsor_out_if.source      out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [17:0] cfg_data
);
  localparam int RAW  = $clog2(MAX_ROWS);
  localparam int RCW  = $clog2(MAX_ROWS + 1);
  localparam int NZAW = $clog2(MAX_NONZEROS);
  localparam int NZCW = $clog2(MAX_NONZEROS + 1);
  localparam int QW   = sbsor_pkg::QW;
  localparam int QLB  = sbsor_pkg::QL_BITS;
  localparam logic [31:0] ONE_Q = 32'd1 << FRAC_BITS;
  localparam logic [63:0] I64_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] I64_MIN = {1'b1, {63{1'b0}}};

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_READ  = 5'd1;
  localparam logic [4:0] S_SWEEP = 5'd2;
  localparam logic [4:0] S_ROW   = 5'd3;
  localparam logic [4:0] S_RS0   = 5'd4;
  localparam logic [4:0] S_RS1   = 5'd5;
  localparam logic [4:0] S_NZ    = 5'd6;
  localparam logic [4:0] S_NZD   = 5'd7;
  localparam logic [4:0] S_XD    = 5'd8;
  localparam logic [4:0] S_M1    = 5'd9;
  localparam logic [4:0] S_M2    = 5'd10;
  localparam logic [4:0] S_M3    = 5'd11;
  localparam logic [4:0] S_M4    = 5'd12;
  localparam logic [4:0] S_F     = 5'd13;
  localparam logic [4:0] S_RES   = 5'd14;
  localparam logic [4:0] S_N0    = 5'd15;
  localparam logic [4:0] S_N1    = 5'd16;
  localparam logic [4:0] S_N2    = 5'd17;
  localparam logic [4:0] S_N3    = 5'd18;
  localparam logic [4:0] S_N4    = 5'd19;
  localparam logic [4:0] S_N5    = 5'd20;
  localparam logic [4:0] S_N6    = 5'd21;
  localparam logic [4:0] S_DIV   = 5'd22;
  localparam logic [4:0] S_DIVW  = 5'd23;
  localparam logic [4:0] S_W0    = 5'd24;
  localparam logic [4:0] S_W1    = 5'd25;
  localparam logic [4:0] S_W2    = 5'd26;
  localparam logic [4:0] S_W3    = 5'd27;
  localparam logic [4:0] S_W4    = 5'd28;
  localparam logic [4:0] S_FIN   = 5'd29;

  function automatic logic [64:0] sadd(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sadd = {1'b1, s[64] ? I64_MIN : I64_MAX};
    else sadd = {1'b0, s[63:0]};
  endfunction

  function automatic logic [63:0] negs(input logic [63:0] a);
    negs = (a == I64_MIN) ? I64_MAX : 64'(-a);
  endfunction

  // floor shift by FRAC_BITS, clip to 32 bits; top bit flags a clip
  function automatic logic [32:0] clip_sh(input logic signed [63:0] t);
    logic signed [63:0] v;
    v = t >>> FRAC_BITS;
    if ((&v[63:31]) || !(|v[63:31])) clip_sh = {1'b0, v[31:0]};
    else clip_sh = {1'b1, v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF};
  endfunction

  // configuration
  logic [17:0] w_r;
  logic [7:0]  lim_r;
  logic [10:0] rc_r;
  logic        cm_r;

  // control
  logic [4:0]     st_r;
  logic           out_valid_r;
  logic           sat_flag_r;
  logic [1:0]     fin_st_r;
  logic [7:0]     k_r;
  logic [RCW-1:0] i_r;

  // datapath
  sbsor_pkg::out_item_t out_data_r;
  logic                 rd_ok_r;
  logic [NZCW-1:0]      j_r;
  logic [NZCW-1:0]      e_r;
  logic signed [31:0]   ar_r, ai_r, xr_r, xi_r, dr_r, di_r;
  logic                 have_r;
  logic [63:0]          accr_r, acci_r, den_r, t_r;
  logic signed [63:0]   p_r;
  logic signed [31:0]   r_r, si_r, xo_re_r, xo_im_r;
  logic                 sel_im_r;
  logic signed [QW-1:0] q_r;

  // memories
  logic [13:0]        rs_mem [MAX_ROWS + 1];
  logic [9:0]         nzc_mem [MAX_NONZEROS];
  logic signed [31:0] nzr_mem [MAX_NONZEROS];
  logic signed [31:0] nzi_mem [MAX_NONZEROS];
  logic signed [31:0] xr_mem [MAX_ROWS];
  logic signed [31:0] xi_mem [MAX_ROWS];
  logic signed [31:0] fr_mem [MAX_ROWS];
  logic signed [31:0] fi_mem [MAX_ROWS];
  logic [13:0]        rs_q;
  logic [9:0]         nzc_q;
  logic signed [31:0] nzr_q, nzi_q, xr_q, xi_q, fr_q, fi_q;

  // combinational
  logic               acc;
  logic [2:0]         cmd;
  logic [31:0]        idx32;
  logic               idx_row_ok, idx_rs_ok, idx_nz_ok;
  logic [RCW-1:0]     rows_c;
  logic [NZCW-1:0]    rs_clamp;
  logic               col_diag, col_ok;
  logic [RCW-1:0]     rs_ra;
  logic [RAW-1:0]     x_ra, x_wa;
  logic               rs_we, nz_we, f_we, x_we_re, x_we_im;
  logic signed [31:0] x_wd_re, x_wd_im;
  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod;
  logic [63:0]        sa_a, sa_b;
  logic [64:0]        sa;
  logic [63:0]        fre, fim;
  logic [64:0]        rr_s, ri_s;
  logic [32:0]        rc, ic, wc;
  logic signed [31:0] old_x;
  logic               sat_hit;
  logic               res_load;
  sbsor_pkg::out_item_t res_nxt;
  logic               div_done;
  sbsor_pkg::div_res_t div_res;

  assign acc        = in_ch.valid && in_ch.ready;
  assign cmd        = in_ch.data.cmd;
  assign idx32      = 32'(in_ch.data.index);
  assign idx_row_ok = idx32 < 32'(MAX_ROWS);
  assign idx_rs_ok  = idx32 <= 32'(MAX_ROWS);
  assign idx_nz_ok  = idx32 < 32'(MAX_NONZEROS);
  assign rows_c     = (32'(rc_r) > 32'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(rc_r);
  assign rs_clamp   = (32'(rs_q) > 32'(MAX_NONZEROS)) ? NZCW'(MAX_NONZEROS) : NZCW'(rs_q);
  assign col_diag   = 32'(nzc_q) == 32'(i_r);
  assign col_ok     = 32'(nzc_q) < 32'(MAX_ROWS);
  assign old_x      = sel_im_r ? xo_im_r : xo_re_r;

  assign in_ch.ready  = (st_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // memory addressing
  always_comb begin
    case (st_r)
      S_ROW:   rs_ra = i_r - RCW'(1);
      S_RS0:   rs_ra = i_r + RCW'(1);
      default: rs_ra = RCW'(in_ch.data.index);
    endcase
    case (st_r)
      S_NZD:   x_ra = RAW'(nzc_q);
      S_F:     x_ra = RAW'(i_r);
      default: x_ra = RAW'(in_ch.data.index);
    endcase
    rs_we   = acc && cmd == sbsor_pkg::CMD_ROW_START && idx_rs_ok;
    nz_we   = acc && cmd == sbsor_pkg::CMD_NONZERO && idx_nz_ok;
    f_we    = acc && cmd == sbsor_pkg::CMD_LOAD_F && idx_row_ok;
    x_we_re = (acc && cmd == sbsor_pkg::CMD_LOAD_X && idx_row_ok) ||
              (st_r == S_W4 && !sel_im_r);
    x_we_im = (acc && cmd == sbsor_pkg::CMD_LOAD_X && idx_row_ok) ||
              (st_r == S_W4 && sel_im_r);
    x_wa    = (st_r == S_W4) ? RAW'(i_r) : RAW'(in_ch.data.index);
    x_wd_re = (st_r == S_W4) ? wc[31:0] : in_ch.data.re_value;
    x_wd_im = (st_r == S_W4) ? wc[31:0] : in_ch.data.im_value;
  end

  always_ff @(posedge clk) begin
    if (rs_we) rs_mem[RCW'(in_ch.data.index)] <= in_ch.data.row_start;
    rs_q <= rs_mem[rs_ra];
  end

  always_ff @(posedge clk) begin
    if (nz_we) begin
      nzc_mem[NZAW'(in_ch.data.index)] <= in_ch.data.column;
      nzr_mem[NZAW'(in_ch.data.index)] <= in_ch.data.re_value;
      nzi_mem[NZAW'(in_ch.data.index)] <= in_ch.data.im_value;
    end
    nzc_q <= nzc_mem[j_r[NZAW-1:0]];
    nzr_q <= nzr_mem[j_r[NZAW-1:0]];
    nzi_q <= nzi_mem[j_r[NZAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (x_we_re) xr_mem[x_wa] <= x_wd_re;
    xr_q <= xr_mem[x_ra];
  end

  always_ff @(posedge clk) begin
    if (x_we_im) xi_mem[x_wa] <= x_wd_im;
    xi_q <= xi_mem[x_ra];
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      fr_mem[RAW'(in_ch.data.index)] <= in_ch.data.re_value;
      fi_mem[RAW'(in_ch.data.index)] <= in_ch.data.im_value;
    end
    fr_q <= fr_mem[RAW'(i_r)];
    fi_q <= fi_mem[RAW'(i_r)];
  end

  // shared multiplier operands
  always_comb begin
    case (st_r)
      S_XD:    begin op_a = ar_r; op_b = xr_q; end
      S_M1:    begin op_a = ai_r; op_b = xi_r; end
      S_M2:    begin op_a = ar_r; op_b = xi_r; end
      S_M3:    begin op_a = ai_r; op_b = xr_r; end
      S_N0:    begin op_a = r_r;  op_b = dr_r; end
      S_N1:    begin op_a = si_r; op_b = di_r; end
      S_N2:    begin op_a = si_r; op_b = dr_r; end
      S_N3:    begin op_a = r_r;  op_b = di_r; end
      S_N4:    begin op_a = dr_r; op_b = dr_r; end
      S_N5:    begin op_a = di_r; op_b = di_r; end
      S_W0:    begin op_a = {14'd0, w_r}; op_b = {{(32-QLB){1'b0}}, q_r[QLB-1:0]}; end
      S_W1:    begin
        op_a = {14'd0, w_r};
        op_b = {{(32-(QW-QLB)){q_r[QW-1]}}, q_r[QW-1:QLB]};
      end
      S_W2:    begin op_a = ONE_Q - {14'd0, w_r}; op_b = old_x; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end
  assign prod = op_a * op_b;

  // shared saturating accumulator and residual path
  always_comb begin
    sa_a = (st_r == S_M3 || st_r == S_M4 || st_r == S_N4) ? acci_r : accr_r;
    sa_b = (st_r == S_M2 || st_r == S_N4) ? 64'(-p_r) : p_r;
    sa   = sadd(sa_a, sa_b);
    fre  = 64'(fr_q) << FRAC_BITS;
    fim  = cm_r ? (64'(fi_q) << FRAC_BITS) : 64'd0;
    rr_s = sadd(fre, negs(accr_r));
    ri_s = sadd(fim, negs(acci_r));
    rc   = clip_sh(rr_s[63:0]);
    ic   = clip_sh(ri_s[63:0]);
    wc   = clip_sh(t_r);
    case (st_r)
      S_M1, S_M2, S_M3, S_M4, S_N2, S_N4: sat_hit = sa[64];
      S_RES:   sat_hit = rr_s[64] | ri_s[64] | rc[32] | ic[32];
      S_DIVW:  sat_hit = div_done & div_res.sat;
      S_W4:    sat_hit = wc[32];
      default: sat_hit = 1'b0;
    endcase
  end

  // result slot
  always_comb begin
    res_load          = 1'b0;
    res_nxt.status    = sbsor_pkg::STAT_LOAD_OK;
    res_nxt.out_re    = '0;
    res_nxt.out_im    = '0;
    res_nxt.saturated = sat_flag_r;
    case (st_r)
      S_IDLE: res_load = acc && cmd != sbsor_pkg::CMD_RUN && cmd != sbsor_pkg::CMD_READ_X;
      S_READ: begin
        res_load       = 1'b1;
        res_nxt.status = sbsor_pkg::STAT_READ_DATA;
        res_nxt.out_re = rd_ok_r ? xr_q : 32'sd0;
        res_nxt.out_im = (rd_ok_r && cm_r) ? xi_q : 32'sd0;
      end
      S_FIN: begin
        res_load       = !out_valid_r || out_ch.ready;
        res_nxt.status = fin_st_r;
      end
      default: res_load = 1'b0;
    endcase
  end

  sbsor_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_r == S_DIV),
    .num   (sel_im_r ? acci_r : accr_r),
    .den   (den_r),
    .done  (div_done),
    .res   (div_res)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      sat_flag_r  <= 1'b0;
      fin_st_r    <= sbsor_pkg::STAT_RUN_DONE;
      k_r         <= '0;
      i_r         <= '0;
      w_r         <= 18'(ONE_Q);
      lim_r       <= 8'd1;
      rc_r        <= 11'd1;
      cm_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sbsor_pkg::CFG_RELAX_WEIGHT: w_r   <= cfg_data;
          sbsor_pkg::CFG_SWEEP_LIMIT:  lim_r <= cfg_data[7:0];
          sbsor_pkg::CFG_ROW_COUNT:    rc_r  <= cfg_data[10:0];
          sbsor_pkg::CFG_COMPLEX_MODE: cm_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (res_load) out_valid_r <= 1'b1;
      if (st_r == S_IDLE && acc && cmd == sbsor_pkg::CMD_RUN) sat_flag_r <= 1'b0;
      else if (sat_hit) sat_flag_r <= 1'b1;

      case (st_r)
        S_IDLE: begin
          if (acc && cmd == sbsor_pkg::CMD_RUN) begin
            k_r  <= '0;
            st_r <= S_SWEEP;
          end else if (acc && cmd == sbsor_pkg::CMD_READ_X) begin
            st_r <= S_READ;
          end
        end
        S_READ: st_r <= S_IDLE;
        S_SWEEP: begin
          if (k_r == lim_r) begin
            fin_st_r <= sbsor_pkg::STAT_RUN_DONE;
            st_r     <= S_FIN;
          end else begin
            k_r  <= k_r + 8'd1;
            i_r  <= rows_c;
            st_r <= S_ROW;
          end
        end
        S_ROW: begin
          if (i_r == '0) st_r <= S_SWEEP;
          else begin
            i_r  <= i_r - RCW'(1);
            st_r <= S_RS0;
          end
        end
        S_RS0: st_r <= S_RS1;
        S_RS1: st_r <= S_NZ;
        S_NZ:  st_r <= (j_r < e_r) ? S_NZD : S_F;
        S_NZD: st_r <= (!col_diag && col_ok) ? S_XD : S_NZ;
        S_XD:  st_r <= S_M1;
        S_M1:  st_r <= S_M2;
        S_M2:  st_r <= S_M3;
        S_M3:  st_r <= S_M4;
        S_M4:  st_r <= S_NZ;
        S_F: begin
          if (!have_r || (dr_r == '0 && di_r == '0)) begin
            fin_st_r <= sbsor_pkg::STAT_ZERO_DIAG;
            st_r     <= S_FIN;
          end else begin
            st_r <= S_RES;
          end
        end
        S_RES: st_r <= S_N0;
        S_N0:  st_r <= S_N1;
        S_N1:  st_r <= S_N2;
        S_N2:  st_r <= S_N3;
        S_N3:  st_r <= S_N4;
        S_N4:  st_r <= S_N5;
        S_N5:  st_r <= S_N6;
        S_N6:  st_r <= S_DIV;
        S_DIV: st_r <= S_DIVW;
        S_DIVW: if (div_done) st_r <= S_W0;
        S_W0:  st_r <= S_W1;
        S_W1:  st_r <= S_W2;
        S_W2:  st_r <= S_W3;
        S_W3:  st_r <= S_W4;
        S_W4:  st_r <= (!sel_im_r && cm_r) ? S_DIV : S_ROW;
        S_FIN: if (res_load) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    p_r <= prod;
    if (res_load) out_data_r <= res_nxt;
    case (st_r)
      S_IDLE: rd_ok_r <= idx_row_ok;
      S_ROW: begin
        accr_r <= '0;
        acci_r <= '0;
        have_r <= 1'b0;
        dr_r   <= '0;
        di_r   <= '0;
      end
      S_RS0: j_r <= rs_clamp;
      S_RS1: e_r <= rs_clamp;
      S_NZ:  if (j_r < e_r) j_r <= j_r + NZCW'(1);
      S_NZD: begin
        ar_r <= nzr_q;
        ai_r <= cm_r ? nzi_q : 32'sd0;
        // last diagonal entry in the row wins
        if (col_diag) begin
          dr_r   <= nzr_q;
          di_r   <= cm_r ? nzi_q : 32'sd0;
          have_r <= 1'b1;
        end
      end
      S_XD: begin
        xr_r <= xr_q;
        xi_r <= cm_r ? xi_q : 32'sd0;
      end
      S_M1, S_M2: accr_r <= sa[63:0];
      S_M3, S_M4: acci_r <= sa[63:0];
      S_RES: begin
        r_r     <= rc[31:0];
        si_r    <= ic[31:0];
        xo_re_r <= xr_q;
        xo_im_r <= xi_q;
      end
      S_N1: accr_r <= p_r;
      S_N2: accr_r <= sa[63:0];
      S_N3: acci_r <= p_r;
      S_N4: acci_r <= sa[63:0];
      S_N5: den_r  <= p_r;
      S_N6: begin
        den_r    <= den_r + p_r;
        sel_im_r <= 1'b0;
      end
      S_DIVW: if (div_done) q_r <= div_res.q;
      S_W1: t_r <= p_r;
      S_W2: t_r <= t_r + 64'(p_r <<< QLB);
      S_W3: t_r <= t_r + p_r;
      S_W4: if (!sel_im_r && cm_r) sel_im_r <= 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### hdl/sbsor_div.sv
`default_nettype none
module sbsor_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic signed [63:0]  num,
  input  wire logic [63:0]         den,
  output logic                     done,
  output sbsor_pkg::div_res_t      res
);
  localparam int DW = 64 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);
  localparam int QB = sbsor_pkg::Q_CAP_BITS;
  localparam int QW = sbsor_pkg::QW;

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [63:0]       rem_r;
  logic [DW-1:0]     dvd_r;
  logic [QB:0]       quo_r;
  logic              ovf_r;
  logic              neg_r;
  sbsor_pkg::div_res_t res_r;

  logic [64:0]       rem_sh;
  logic              ge;
  logic [64:0]       rem_new;
  logic [63:0]       mag_in;
  logic              ov;
  logic [QB:0]       qmag;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[DW-1]};
    ge      = rem_sh >= {1'b0, den};
    rem_new = ge ? (rem_sh - {1'b0, den}) : rem_sh;
    mag_in  = num[63] ? 64'(-num) : num;
    ov      = ovf_r | quo_r[QB];
    qmag    = ov ? {1'b1, {QB{1'b0}}} : quo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      neg_r <= num[63];
      dvd_r <= {mag_in, {FRAC_BITS{1'b0}}};
      rem_r <= '0;
      quo_r <= '0;
      ovf_r <= 1'b0;
      cnt_r <= CW'(DW);
    end else if (busy_r && cnt_r != '0) begin
      rem_r <= rem_new[63:0];
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      quo_r <= {quo_r[QB-1:0], ge};
      ovf_r <= ovf_r | quo_r[QB];
      cnt_r <= cnt_r - CW'(1);
    end else if (busy_r) begin
      res_r.q   <= neg_r ? -QW'(qmag) : QW'(qmag);
      res_r.sat <= ov;
    end
  end

  assign done = done_r;
  assign res  = res_r;
endmodule
`default_nettype wire
